// ===== rtl/core/page_frame_allocator_frag_macros.svh =====
// Assertion macros used by the checker of the page frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_FRAG_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_FRAG_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pfa_pkg.sv =====
// Shared constants, types and codes of the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int ADDR_BITS  = 12;
  localparam int PID_BITS   = 8;
  localparam int MIN_N      = 4;
  localparam int MAX_N      = (ADDR_BITS < 11) ? ADDR_BITS : 11;
  localparam int IDX_W      = MAX_N;
  localparam int CNT_W      = MAX_N + 1;
  localparam int MAX_FRAMES = 1 << MAX_N;
  localparam int N_W        = 4;
  localparam int SIZE_W     = 13;
  localparam int PID_IN_W   = 8;
  localparam int OWN_W      = (PID_BITS < PID_IN_W) ? PID_BITS : PID_IN_W;
  localparam int USED_W     = ADDR_BITS - MIN_N + 1;
  localparam int NEED_W     = ((SIZE_W > USED_W) ? SIZE_W : USED_W) + 1;
  localparam int TOT_W      = ADDR_BITS + 1;
  localparam int SUM_W      = 13;
  localparam int CMP_W      = (TOT_W > SUM_W) ? TOT_W : SUM_W;
  localparam int GRANT_W    = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [SUM_W-1:0] SUM_MAX     = '1;
  localparam logic [N_W-1:0]   PCB_RESET   = N_W'(4);
  localparam logic [SUM_W-1:0] LIMIT_RESET = SUM_W'(2048);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_UNLOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LIMIT    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [OWN_W-1:0]  owner;
    logic [USED_W-1:0] used;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } tbl_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]   unused_total;
    logic               over_limit;
    logic [SUM_W-1:0]   largest_unused;
    logic [GRANT_W-1:0] frames_granted;
    logic               load_short;
  } result_t;

endpackage

// ===== rtl/core/pfa_frame_table.sv =====
// Frame table memory: one entry per frame, one write and one registered read a cycle.
`timescale 1ns / 1ps
module pfa_frame_table import pfa_pkg::*; (
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rdata
);

  entry_t mem [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/core/pfa_ctrl.sv =====
// Sequencer that clears, scans and updates the frame table and keeps the unused byte totals.
`timescale 1ns / 1ps
module pfa_ctrl import pfa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear_start,
  input  logic [N_W-1:0]      n_eff,
  input  logic [SUM_W-1:0]    unused_limit,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [PID_IN_W-1:0] process_id,
  input  logic [SIZE_W-1:0]   process_size,
  output tbl_req_t            treq,
  input  entry_t              tbl_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output result_t             res
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic               rd_pend, rd_pend_next;
  logic [IDX_W-1:0]   rd_addr, rd_addr_next;
  logic               op, op_next;
  logic [OWN_W-1:0]   pid, pid_next;
  logic [NEED_W-1:0]  need, need_next;
  logic [USED_W-1:0]  last_unused, last_unused_next;
  logic [CNT_W-1:0]   granted, granted_next;
  logic [TOT_W-1:0]   total, total_next;
  logic [SUM_W-1:0]   largest, largest_next;

  logic [USED_W-1:0]  pg_shift;
  logic [USED_W-1:0]  ps;
  logic [CNT_W-1:0]   frames;
  logic [NEED_W-1:0]  need_calc;
  logic [NEED_W-1:0]  rem;
  logic [USED_W-1:0]  last_used;
  logic               issue;
  logic [SUM_W-1:0]   sum_sat;
  logic               over;

  assign pg_shift  = USED_W'(ADDR_BITS) - USED_W'(n_eff);
  assign ps        = USED_W'(1) << pg_shift;
  assign frames    = CNT_W'(1) << n_eff;
  assign need_calc = (NEED_W'(process_size) + NEED_W'(ps) - NEED_W'(1)) >> pg_shift;
  assign rem       = NEED_W'(process_size) & (NEED_W'(ps) - NEED_W'(1));
  // The final frame holds the remainder, or a whole page when the size divides evenly.
  assign last_used = (rem == '0) ? ps : rem[USED_W-1:0];

  assign sum_sat = (CMP_W'(total) > CMP_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
  assign over    = sum_sat > unused_limit;

  always_comb begin
    res.unused_total   = sum_sat;
    res.over_limit     = over;
    res.largest_unused = (!over && sum_sat > largest) ? sum_sat : largest;
    res.frames_granted = GRANT_W'(granted);
    res.load_short     = (op == REQ_LOAD) && (NEED_W'(granted) < need);
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    rd_pend_next     = 1'b0;
    rd_addr_next     = rd_addr;
    op_next          = op;
    pid_next         = pid;
    need_next        = need;
    last_unused_next = last_unused;
    granted_next     = granted;
    total_next       = total;
    largest_next     = largest;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    issue            = 1'b0;
    treq             = '0;
    case (state)
      ST_CLEAR: begin
        treq.we    = 1'b1;
        treq.waddr = idx[IDX_W-1:0];
        idx_next   = idx + CNT_W'(1);
        if (idx == CNT_W'(MAX_FRAMES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next          = req_type;
          pid_next         = process_id[OWN_W-1:0];
          need_next        = need_calc;
          last_unused_next = ps - last_used;
          granted_next     = '0;
          idx_next         = '0;
          state_next       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A load stops reading once it holds every frame it asked for; one extra read
        // may still be in flight and is then ignored.
        issue = (idx != frames) && !((op == REQ_LOAD) && (NEED_W'(granted) >= need));
        treq.re    = issue;
        treq.raddr = idx[IDX_W-1:0];
        if (issue) begin
          idx_next     = idx + CNT_W'(1);
          rd_pend_next = 1'b1;
          rd_addr_next = idx[IDX_W-1:0];
        end
        if (rd_pend) begin
          if (op == REQ_LOAD) begin
            if (!tbl_rdata.valid && (NEED_W'(granted) < need)) begin
              treq.we          = 1'b1;
              treq.waddr       = rd_addr;
              treq.wdata.valid = 1'b1;
              treq.wdata.owner = pid;
              if (NEED_W'(granted) + NEED_W'(1) == need) begin
                treq.wdata.used = ps - last_unused;
                total_next      = total + TOT_W'(last_unused);
              end else begin
                treq.wdata.used = ps;
              end
              granted_next = granted + CNT_W'(1);
            end
          end else if (tbl_rdata.valid && (tbl_rdata.owner == pid)) begin
            treq.we    = 1'b1;
            treq.waddr = rd_addr;
            total_next = total - TOT_W'(ps - tbl_rdata.used);
          end
        end
        if (!issue && !rd_pend) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          largest_next = res.largest_unused;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        idx_next   = '0;
      end
    endcase
  end

  // A new page size starts a fresh run, so its write restarts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      state   <= ST_CLEAR;
      idx     <= '0;
      rd_pend <= 1'b0;
      total   <= '0;
      largest <= '0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      rd_pend <= rd_pend_next;
      total   <= total_next;
      largest <= largest_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr     <= rd_addr_next;
    op          <= op_next;
    pid         <= pid_next;
    need        <= need_next;
    last_unused <= last_unused_next;
    granted     <= granted_next;
  end

endmodule

// ===== rtl/core/page_frame_allocator_frag.sv =====
// Top level of the first-fit page frame allocator with its unused byte monitor.
//
//   channel   direction  handshake                    payload
//   in        request    in_valid / in_ready          req_type, process_id, process_size
//   out       result     out_valid / out_ready        unused_total, over_limit,
//                                                     largest_unused, frames_granted, load_short
//   cfg       write      cfg_write_en                 cfg_index, cfg_wdata
//
// A request scans the 2^n frames in use one table entry per cycle through the single
// read and write port of the frame table; a load finishes early once all of its
// frames are claimed. One request is worked on at a time. After reset, and after each
// write of page_count_bits, a clearing pass over every frame table entry runs with
// in_ready low. A finished result waits in the output register while the next
// request is taken; the block only holds in its final step while that register is full.
`timescale 1ns / 1ps
module page_frame_allocator_frag import pfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [PID_IN_W-1:0]   process_id,
  input  logic [SIZE_W-1:0]     process_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      unused_total,
  output logic                  over_limit,
  output logic [SUM_W-1:0]      largest_unused,
  output logic [GRANT_W-1:0]    frames_granted,
  output logic                  load_short,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [N_W-1:0]   page_count_bits;
  logic [SUM_W-1:0] unused_limit;
  logic [N_W-1:0]   n_eff;
  logic             clear_start;
  tbl_req_t         treq;
  entry_t           tbl_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  assign clear_start = cfg_write_en && (cfg_index == REG_PAGE_COUNT_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count_bits <= PCB_RESET;
      unused_limit    <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_PAGE_COUNT_BITS: page_count_bits <= cfg_wdata[N_W-1:0];
        REG_UNUSED_LIMIT:    unused_limit    <= cfg_wdata[SUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame counts outside the supported span are pulled to its nearer end.
  always_comb begin
    if (page_count_bits < N_W'(MIN_N)) begin
      n_eff = N_W'(MIN_N);
    end else if (page_count_bits > N_W'(MAX_N)) begin
      n_eff = N_W'(MAX_N);
    end else begin
      n_eff = page_count_bits;
    end
  end

  pfa_frame_table u_table (
    .clk   (clk),
    .req   (treq),
    .rdata (tbl_rdata)
  );

  pfa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .clear_start  (clear_start),
    .n_eff        (n_eff),
    .unused_limit (unused_limit),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .process_id   (process_id),
    .process_size (process_size),
    .treq         (treq),
    .tbl_rdata    (tbl_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      unused_total   <= res.unused_total;
      over_limit     <= res.over_limit;
      largest_unused <= res.largest_unused;
      frames_granted <= res.frames_granted;
      load_short     <= res.load_short;
    end
  end

endmodule

// ===== rtl/core/pfa_checker.sv =====
// Port-level checker of the page frame allocator and its bind to the top level.
`timescale 1ns / 1ps
`include "page_frame_allocator_frag_macros.svh"
module pfa_checker import pfa_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SUM_W-1:0]   unused_total,
  input logic               over_limit,
  input logic [SUM_W-1:0]   largest_unused,
  input logic [GRANT_W-1:0] frames_granted
);

  // Only one request is worked on at a time.
  `PFA_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request taken while busy")

  // A total within the limit is always covered by the running maximum.
  `PFA_ASSERT_SAME(a_largest_covers, out_valid && !over_limit, largest_unused >= unused_total, "largest below total")

  // No load can claim more frames than the table holds.
  `PFA_ASSERT_SAME(a_grant_bound, out_valid, frames_granted <= GRANT_W'(MAX_FRAMES), "grant too large")

  // A stalled result holds its value.
  `PFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(unused_total) && $stable(largest_unused) && $stable(frames_granted), "stalled result changed")

endmodule

bind page_frame_allocator_frag pfa_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .unused_total   (unused_total),
  .over_limit     (over_limit),
  .largest_unused (largest_unused),
  .frames_granted (frames_granted)
);

// ===== test/tb_page_frame_allocator_frag.sv =====
// Self-checking testbench for the first-fit page frame allocator and its unused byte monitor.
`timescale 1ns / 1ps

import pfa_pkg::*;

class alloc_scoreboard;
  bit               frame_busy [MAX_FRAMES];
  logic [OWN_W-1:0] frame_pid  [MAX_FRAMES];
  int unsigned      frame_fill [MAX_FRAMES];
  int unsigned      pcb_reg;
  int unsigned      limit_reg;
  int unsigned      unused_now;
  int unsigned      unused_peak;
  result_t          expected_results [$];
  int               mismatches;

  function new();
    pcb_reg = 32'(PCB_RESET);
    limit_reg = 32'(LIMIT_RESET);
    mismatches = 0;
    clear_table();
  endfunction

  function void clear_table();
    foreach (frame_busy[i]) frame_busy[i] = 1'b0;
    unused_now = 0;
    unused_peak = 0;
  endfunction

  // Out-of-range frame counts are clamped to what the address space allows.
  function int unsigned frame_bits();
    int unsigned n;
    n = pcb_reg;
    if (n < MIN_N) n = MIN_N;
    if (n > MAX_N) n = MAX_N;
    return n;
  endfunction

  function int unsigned page_bytes();
    return 1 << (ADDR_BITS - frame_bits());
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_PAGE_COUNT_BITS) begin
      pcb_reg = 32'(data[N_W-1:0]);
      clear_table();
    end else if (idx == REG_UNUSED_LIMIT) begin
      limit_reg = 32'(data);
    end
  endfunction

  function void note_request(logic rtype, logic [PID_IN_W-1:0] pid, logic [SIZE_W-1:0] size);
    int unsigned     frames;
    int unsigned     ps;
    int unsigned     need;
    int unsigned     tail;
    int unsigned     granted;
    longint unsigned total;
    result_t         r;
    frames = 1 << frame_bits();
    ps = page_bytes();
    need = 0;
    granted = 0;
    total = 0;
    if (rtype == REQ_LOAD) begin
      need = (int'(size) + ps - 1) / ps;
      tail = (need > 0) ? int'(size) - (need - 1) * ps : 0;
      // Every frame but the last one claimed is filled completely.
      for (int i = 0; i < frames && granted < need; i++) begin
        if (!frame_busy[i]) begin
          frame_busy[i] = 1'b1;
          frame_pid[i] = pid[OWN_W-1:0];
          frame_fill[i] = (granted + 1 == need) ? tail : ps;
          granted++;
        end
      end
    end else begin
      for (int i = 0; i < frames; i++) begin
        if (frame_busy[i] && frame_pid[i] == pid[OWN_W-1:0]) frame_busy[i] = 1'b0;
      end
    end
    for (int i = 0; i < frames; i++) begin
      if (frame_busy[i] && ps > frame_fill[i]) total += 64'(ps - frame_fill[i]);
    end
    unused_now = (total > 64'(SUM_MAX)) ? 32'(SUM_MAX) : 32'(total);
    r.over_limit = unused_now > limit_reg;
    if (!r.over_limit && unused_now > unused_peak) unused_peak = unused_now;
    r.unused_total = SUM_W'(unused_now);
    r.largest_unused = SUM_W'(unused_peak);
    r.frames_granted = GRANT_W'(granted);
    r.load_short = (granted < need);
    expected_results.push_back(r);
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 100) $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(logic [SUM_W-1:0] total, logic over, logic [SUM_W-1:0] peak,
                    logic [GRANT_W-1:0] granted, logic shortfall);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result arrived with no request outstanding");
      return;
    end
    want = expected_results.pop_front();
    if (total !== want.unused_total)
      report_mismatch($sformatf("unused_total got %0d want %0d", total, want.unused_total));
    if (over !== want.over_limit)
      report_mismatch($sformatf("over_limit got %0b want %0b", over, want.over_limit));
    if (peak !== want.largest_unused)
      report_mismatch($sformatf("largest_unused got %0d want %0d", peak, want.largest_unused));
    if (granted !== want.frames_granted)
      report_mismatch($sformatf("frames_granted got %0d want %0d", granted,
                                want.frames_granted));
    if (shortfall !== want.load_short)
      report_mismatch($sformatf("load_short got %0b want %0b", shortfall, want.load_short));
  endtask
endclass

module tb_page_frame_allocator_frag;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_LOAD;
  logic [PID_IN_W-1:0]   process_id = '0;
  logic [SIZE_W-1:0]     process_size = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SUM_W-1:0]      unused_total;
  logic                  over_limit;
  logic [SUM_W-1:0]      largest_unused;
  logic [GRANT_W-1:0]    frames_granted;
  logic                  load_short;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          sender_idle_pct = 36;
  int          receiver_idle_pct = 47;
  int unsigned cycle_count = 0;
  alloc_scoreboard sb;

  page_frame_allocator_frag u_top (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(req_type, process_id, process_size);
      if (out_valid && out_ready)
        sb.check_result(unused_total, over_limit, largest_unused, frames_granted, load_short);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("page_frame_allocator_frag verification failed");
      $finish;
    end
  end

  task automatic send_request(logic rtype, logic [PID_IN_W-1:0] pid, logic [SIZE_W-1:0] size);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rtype;
    process_id <= pid;
    process_size <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Requests mostly come from a small pool of processes so that unloads find owned frames.
  task automatic run_phase(bit set_pcb, logic [N_W-1:0] pcb, logic [SUM_W-1:0] limit,
                           int count, int tx_pct, int rx_pct);
    int unsigned         ps;
    int unsigned         sel;
    logic                rtype;
    logic [PID_IN_W-1:0] pid;
    logic [PID_IN_W-1:0] pid_base;
    logic [SIZE_W-1:0]   size;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    write_reg(REG_UNUSED_LIMIT, limit);
    if (set_pcb) write_reg(REG_PAGE_COUNT_BITS, CFG_DATA_W'({$urandom_range(511), pcb}));
    sender_idle_pct = tx_pct;
    receiver_idle_pct = rx_pct;
    ps = sb.page_bytes();
    pid_base = PID_IN_W'($urandom_range(255));
    for (int k = 0; k < count; k++) begin
      rtype = ($urandom_range(99) < 60) ? REQ_LOAD : REQ_UNLOAD;
      if ($urandom_range(99) < 80) pid = PID_IN_W'(pid_base + $urandom_range(7));
      else pid = PID_IN_W'($urandom_range(255));
      sel = $urandom_range(99);
      if (rtype == REQ_UNLOAD) size = SIZE_W'($urandom);
      else if (sel < 5) size = '0;
      else if (sel < 35) size = SIZE_W'($urandom_range(ps * 3, 1));
      else if (sel < 85) size = SIZE_W'($urandom_range(1024, 1));
      else if (sel < 95) size = SIZE_W'($urandom_range(4096, 0));
      else size = SIZE_W'($urandom);
      send_request(rtype, pid, size);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset page size of 256 bytes and 16 frames.
    send_request(REQ_LOAD, 8'd0, 13'd0);
    send_request(REQ_LOAD, 8'd1, 13'd1);
    send_request(REQ_LOAD, 8'd255, 13'd256);
    send_request(REQ_LOAD, 8'd2, 13'd257);
    send_request(REQ_LOAD, 8'd1, 13'd300);
    send_request(REQ_UNLOAD, 8'd77, 13'd8191);
    send_request(REQ_LOAD, 8'd3, 13'd4096);
    send_request(REQ_LOAD, 8'd4, 13'd8191);
    send_request(REQ_UNLOAD, 8'd1, 13'd0);
    send_request(REQ_UNLOAD, 8'd255, 13'd4096);
    send_request(REQ_UNLOAD, 8'd2, 13'd0);
    send_request(REQ_UNLOAD, 8'd3, 13'd0);
    send_request(REQ_UNLOAD, 8'd0, 13'd0);
    // Single-byte loads push the unused total past the default limit on the ninth one.
    repeat (9) send_request(REQ_LOAD, 8'd170, 13'd1);
    send_request(REQ_UNLOAD, 8'd170, 13'd0);
    in_valid <= 1'b0;

    run_phase(1'b1, 4'd0, 13'd0, 40, 36, 47);
    run_phase(1'b1, 4'd5, 13'd1000, 40, 36, 47);
    run_phase(1'b1, 4'd15, 13'd4096, 12, 36, 47);
    run_phase(1'b1, 4'd6, 13'd300, 45, 47, 36);
    run_phase(1'b1, 4'd7, 13'd4096, 35, 47, 36);
    run_phase(1'b1, 4'd11, 13'd100, 10, 47, 36);
    run_phase(1'b1, 4'd8, 13'd2048, 50, 0, 0);
    run_phase(1'b0, 4'd8, 13'd600, 35, 0, 0);

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("page_frame_allocator_frag verification clean");
    end else begin
      $display("page_frame_allocator_frag verification failed");
    end
    $finish;
  end
endmodule
